@@ src/pdog_pkg.sv @@
// ----------------------------------------------------------------------------
// pdog_pkg
// Shared types and constants for the pulse direction overcurrent guard.
// ----------------------------------------------------------------------------
package pdog_pkg;

  // Configuration port widths
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 19;

  // Field widths
  localparam int unsigned TimeW  = 32;
  localparam int unsigned PulseW = 16;
  localparam int unsigned CurW   = 20;
  localparam int unsigned LimW   = 19;
  localparam int unsigned DelayW = 16;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PULSE_MIN = 3'd0,
    REG_PULSE_MAX = 3'd1,
    REG_DZ_LOW    = 3'd2,
    REG_DZ_HIGH   = 3'd3,
    REG_CUR_LIMIT = 3'd4,
    REG_START_DLY = 3'd5
  } reg_idx_e;

  // Reset values of the registers
  localparam logic [PulseW-1:0] PulseMinRst = 16'd900;
  localparam logic [PulseW-1:0] PulseMaxRst = 16'd2100;
  localparam logic [PulseW-1:0] DzLowRst    = 16'd1400;
  localparam logic [PulseW-1:0] DzHighRst   = 16'd1600;
  localparam logic [LimW-1:0]   CurLimRst   = 19'd10000;
  localparam logic [DelayW-1:0] StartDlyRst = 16'd500;

  // Direction codes, two's complement
  typedef enum logic [1:0] {
    DIR_STOP = 2'b00,
    DIR_FWD  = 2'b01,
    DIR_REV  = 2'b11
  } dir_e;

  // Configuration register set
  typedef struct packed {
    logic [PulseW-1:0] pulse_min;
    logic [PulseW-1:0] pulse_max;
    logic [PulseW-1:0] dz_low;
    logic [PulseW-1:0] dz_high;
    logic [LimW-1:0]   cur_limit;
    logic [DelayW-1:0] start_dly;
  } cfg_t;

  // One input beat
  typedef struct packed {
    logic [TimeW-1:0]  now_ms;
    logic              sensor_ready;
    logic              motor_running;
    logic [CurW-1:0]   current;
    logic              pulse_valid;
    logic [PulseW-1:0] pulse_width;
  } item_t;

  // One result beat
  typedef struct packed {
    dir_e direction;
    logic changed;
    logic stop_req;
    logic tripped;
    logic prot_active;
    logic blanking;
  } res_t;

endpackage

@@ src/pdog_cfg.sv @@
// ----------------------------------------------------------------------------
// pdog_cfg
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module pdog_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [pdog_pkg::CfgIdxW-1:0]   wr_idx_i,
  input  logic [pdog_pkg::CfgDataW-1:0]  wr_data_i,
  output pdog_pkg::cfg_t                 cfg_o
);

  pdog_pkg::cfg_t cfg_q, cfg_d;

  // Decode the write beat
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_idx_i)
        pdog_pkg::REG_PULSE_MIN: cfg_d.pulse_min = wr_data_i[pdog_pkg::PulseW-1:0];
        pdog_pkg::REG_PULSE_MAX: cfg_d.pulse_max = wr_data_i[pdog_pkg::PulseW-1:0];
        pdog_pkg::REG_DZ_LOW:    cfg_d.dz_low    = wr_data_i[pdog_pkg::PulseW-1:0];
        pdog_pkg::REG_DZ_HIGH:   cfg_d.dz_high   = wr_data_i[pdog_pkg::PulseW-1:0];
        pdog_pkg::REG_CUR_LIMIT: cfg_d.cur_limit = wr_data_i[pdog_pkg::LimW-1:0];
        pdog_pkg::REG_START_DLY: cfg_d.start_dly = wr_data_i[pdog_pkg::DelayW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_min <= pdog_pkg::PulseMinRst;
      cfg_q.pulse_max <= pdog_pkg::PulseMaxRst;
      cfg_q.dz_low    <= pdog_pkg::DzLowRst;
      cfg_q.dz_high   <= pdog_pkg::DzHighRst;
      cfg_q.cur_limit <= pdog_pkg::CurLimRst;
      cfg_q.start_dly <= pdog_pkg::StartDlyRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/pdog_guard.sv @@
// ----------------------------------------------------------------------------
// pdog_guard
// Per-tick guard and pulse decode with the persistent control state.
// ----------------------------------------------------------------------------
module pdog_guard (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  pdog_pkg::cfg_t  cfg_i,
  input  pdog_pkg::item_t item_i,
  output pdog_pkg::res_t  res_o
);

  // Persistent state
  pdog_pkg::dir_e              cmd_dir_q, cmd_dir_d;
  pdog_pkg::dir_e              trip_dir_q, trip_dir_d;
  logic                        latch_q, latch_d;
  logic [pdog_pkg::TimeW-1:0]  stamp_q, stamp_d;
  logic                        was_run_q, was_run_d;
  logic                        blank_q, blank_d;

  // Intermediate terms
  logic [pdog_pkg::TimeW-1:0]  elapsed;
  logic                        blank_st;
  logic                        over;
  logic                        latch_g;
  logic                        in_win;
  pdog_pkg::dir_e              want;
  logic                        opposite;
  logic                        latch_p;

  // Overcurrent guard
  always_comb begin
    stamp_d    = stamp_q;
    was_run_d  = was_run_q;
    blank_st   = blank_q;
    blank_d    = blank_q;
    over       = 1'b0;
    elapsed    = '0;
    if (item_i.sensor_ready) begin
      if (item_i.motor_running) begin
        if (!was_run_q) begin
          stamp_d   = item_i.now_ms;
          was_run_d = 1'b1;
          blank_st  = 1'b1;
        end
        elapsed = item_i.now_ms - stamp_d;
        blank_d = blank_st &&
                  (elapsed < {{(pdog_pkg::TimeW-pdog_pkg::DelayW){1'b0}}, cfg_i.start_dly});
        over    = !blank_d &&
                  ($signed(item_i.current) >= $signed({1'b0, cfg_i.cur_limit}));
      end else begin
        was_run_d = 1'b0;
        blank_d   = 1'b0;
      end
    end
    latch_g    = latch_q || over;
    trip_dir_d = (over && !latch_q) ? cmd_dir_q : trip_dir_q;
  end

  // Pulse decode and latch release
  always_comb begin
    in_win = (item_i.pulse_width >= cfg_i.pulse_min) &&
             (item_i.pulse_width <= cfg_i.pulse_max);
    want = pdog_pkg::DIR_STOP;
    if (in_win) begin
      if (item_i.pulse_width < cfg_i.dz_low) begin
        want = pdog_pkg::DIR_REV;
      end else if (item_i.pulse_width > cfg_i.dz_high) begin
        want = pdog_pkg::DIR_FWD;
      end
    end
    opposite = ((trip_dir_d == pdog_pkg::DIR_FWD) && (want == pdog_pkg::DIR_REV)) ||
               ((trip_dir_d == pdog_pkg::DIR_REV) && (want == pdog_pkg::DIR_FWD));
    latch_p   = latch_g && !(item_i.pulse_valid && in_win && opposite);
    latch_d   = latch_p;
    cmd_dir_d = cmd_dir_q;
    if (item_i.pulse_valid) begin
      cmd_dir_d = latch_p ? pdog_pkg::DIR_STOP : want;
    end
  end

  // Result of this tick
  always_comb begin
    res_o.direction   = cmd_dir_d;
    res_o.changed     = (cmd_dir_d != cmd_dir_q);
    res_o.stop_req    = over;
    res_o.tripped     = over && !latch_q;
    res_o.prot_active = latch_d;
    res_o.blanking    = blank_d;
  end

  // State update once per tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_dir_q  <= pdog_pkg::DIR_STOP;
      trip_dir_q <= pdog_pkg::DIR_STOP;
      latch_q    <= 1'b0;
      stamp_q    <= '0;
      was_run_q  <= 1'b0;
      blank_q    <= 1'b0;
    end else if (step_i) begin
      cmd_dir_q  <= cmd_dir_d;
      trip_dir_q <= trip_dir_d;
      latch_q    <= latch_d;
      stamp_q    <= stamp_d;
      was_run_q  <= was_run_d;
      blank_q    <= blank_d;
    end
  end

endmodule

@@ src/pulse_direction_overcurrent_guard.sv @@
// ----------------------------------------------------------------------------
// pulse_direction_overcurrent_guard
// RC pulse to direction command with a latched overcurrent trip.
// ----------------------------------------------------------------------------
// Usage:
//   One input beat is one control tick (time, sensor and motor flags,
//   current, optional pulse width). Every input beat gives exactly one
//   result beat (direction, change flag, stop request, trip flags, blanking).
//   Input and output use valid/ready; the config port is a separate
//   valid/ready write channel (index, data) that is always ready and must be
//   written only while no tick is in flight.
//   An accepted beat is registered in the input register, evaluated from
//   there and registered in the result register, which drives the outputs.
//   Throughput: one beat per cycle while the receiver keeps up; the tick
//   evaluation is a single pass of compares from the input register into
//   the result register. When the receiver stalls, the result register
//   holds and the input register takes one more beat; after that
//   in_ready_o drops until the result is taken.
//   Reset clears the command to stop, the trip latch and the blanking state,
//   and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pulse_direction_overcurrent_guard (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pdog_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [pdog_pkg::CfgDataW-1:0]       cfg_data_i,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [pdog_pkg::TimeW-1:0]          now_ms_i,
  input  logic                                sensor_ready_i,
  input  logic                                motor_running_i,
  input  logic signed [pdog_pkg::CurW-1:0]    current_tenth_ma_i,
  input  logic                                pulse_valid_i,
  input  logic [pdog_pkg::PulseW-1:0]         pulse_width_us_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [1:0]                   direction_o,
  output logic                                direction_changed_o,
  output logic                                stop_request_o,
  output logic                                protection_tripped_o,
  output logic                                protection_active_o,
  output logic                                startup_blanking_o
);

  pdog_pkg::cfg_t  cfg;
  pdog_pkg::item_t item_q;
  logic            item_vld_q;
  pdog_pkg::res_t  res_d, res_q;
  logic            res_vld_q;
  logic            adv;
  logic            in_acc;

  // Config registers
  assign cfg_ready_o = 1'b1;

  pdog_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // Pipeline control
  assign adv        = item_vld_q && (!res_vld_q || out_ready_i);
  assign in_ready_o = !item_vld_q || adv;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        item_vld_q <= in_valid_i;
      end
      if (adv) begin
        res_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.now_ms        <= now_ms_i;
      item_q.sensor_ready  <= sensor_ready_i;
      item_q.motor_running <= motor_running_i;
      item_q.current       <= current_tenth_ma_i;
      item_q.pulse_valid   <= pulse_valid_i;
      item_q.pulse_width   <= pulse_width_us_i;
    end
  end

  // Tick evaluation
  pdog_guard u_guard (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .cfg_i  (cfg),
    .item_i (item_q),
    .res_o  (res_d)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o          = res_vld_q;
  assign direction_o          = $signed(res_q.direction);
  assign direction_changed_o  = res_q.changed;
  assign stop_request_o       = res_q.stop_req;
  assign protection_tripped_o = res_q.tripped;
  assign protection_active_o  = res_q.prot_active;
  assign startup_blanking_o   = res_q.blanking;

endmodule

@@ tb/tb_pulse_direction_overcurrent_guard.sv @@
// ----------------------------------------------------------------------------
// tb_pulse_direction_overcurrent_guard
// Self-checking bench for the pulse direction overcurrent guard.
// ----------------------------------------------------------------------------
// A directed table of ticks runs first on the reset register values: window
// edges, deadzone edges, blanking start and expiry, a trip and its release,
// sensor skip, negative current and time wrap. Several register sets follow,
// among them all zero, all ones, an empty window and a crossed deadzone,
// each with a few hundred random ticks shaped around the configured edges.
// Every tick is predicted in order and every result beat is compared field
// by field. Both channels idle and stall in random bursts except at the end.
// ----------------------------------------------------------------------------
module tb_pulse_direction_overcurrent_guard;
  timeunit 1ns;
  timeprecision 1ps;

  // Config indexes that map to no register
  localparam logic [pdog_pkg::CfgIdxW-1:0] CfgIdxVoidLo = 3'd6;
  localparam logic [pdog_pkg::CfgIdxW-1:0] CfgIdxVoidHi = 3'd7;

  localparam int unsigned PhaseTicks = 240;
  localparam int unsigned NumPhases  = 6;

  // One row of the directed table
  typedef struct packed {
    pdog_pkg::item_t tick;
    logic            typed;
    pdog_pkg::res_t  want;
  } row_t;

  localparam pdog_pkg::res_t NoRes = '0;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               cfg_valid_i;
  logic                               cfg_ready_o;
  logic [pdog_pkg::CfgIdxW-1:0]       cfg_index_i;
  logic [pdog_pkg::CfgDataW-1:0]      cfg_data_i;
  logic                               in_valid_i;
  logic                               in_ready_o;
  logic [pdog_pkg::TimeW-1:0]         now_ms_i;
  logic                               sensor_ready_i;
  logic                               motor_running_i;
  logic signed [pdog_pkg::CurW-1:0]   current_tenth_ma_i;
  logic                               pulse_valid_i;
  logic [pdog_pkg::PulseW-1:0]        pulse_width_us_i;
  logic                               out_valid_o;
  logic                               out_ready_i;
  logic signed [1:0]                  direction_o;
  logic                               direction_changed_o;
  logic                               stop_request_o;
  logic                               protection_tripped_o;
  logic                               protection_active_o;
  logic                               startup_blanking_o;

  pulse_direction_overcurrent_guard i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .now_ms_i            (now_ms_i),
    .sensor_ready_i      (sensor_ready_i),
    .motor_running_i     (motor_running_i),
    .current_tenth_ma_i  (current_tenth_ma_i),
    .pulse_valid_i       (pulse_valid_i),
    .pulse_width_us_i    (pulse_width_us_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .direction_o         (direction_o),
    .direction_changed_o (direction_changed_o),
    .stop_request_o      (stop_request_o),
    .protection_tripped_o(protection_tripped_o),
    .protection_active_o (protection_active_o),
    .startup_blanking_o  (startup_blanking_o)
  );

  // Guard model state and its register copy
  pdog_pkg::cfg_t  cfg_shadow;
  pdog_pkg::dir_e  cmd_dir;
  logic            trip_latch;
  pdog_pkg::dir_e  trip_dir_q;
  logic [31:0]     run_stamp;
  logic            was_on;
  logic            blank_on;

  pdog_pkg::res_t  pending_res[$];
  row_t            dir_rows[$];
  pdog_pkg::res_t  head_res;
  int unsigned     err_cnt;
  int unsigned     idle_odds;
  logic            calm;
  logic            free_trip;
  logic [31:0]     tick_ms;
  logic            motor_on;

  // Clock, 2 ns period
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // One control tick: guard first, then pulse classification
  function automatic pdog_pkg::res_t guard_tick(pdog_pkg::item_t it);
    pdog_pkg::res_t r;
    pdog_pkg::dir_e want;
    r = '0;
    if (it.sensor_ready) begin
      if (it.motor_running) begin
        if (!was_on) begin
          run_stamp = it.now_ms;
          was_on    = 1'b1;
          blank_on  = 1'b1;
        end
        if (blank_on && (it.now_ms - run_stamp) >= {16'd0, cfg_shadow.start_dly}) begin
          blank_on = 1'b0;
        end
        if (!blank_on && $signed(it.current) >= $signed({1'b0, cfg_shadow.cur_limit})) begin
          if (!trip_latch) begin
            trip_latch = 1'b1;
            trip_dir_q = cmd_dir;
            r.tripped  = 1'b1;
          end
          r.stop_req = 1'b1;
        end
      end else begin
        was_on   = 1'b0;
        blank_on = 1'b0;
      end
    end
    if (it.pulse_valid) begin
      want = pdog_pkg::DIR_STOP;
      if (it.pulse_width >= cfg_shadow.pulse_min && it.pulse_width <= cfg_shadow.pulse_max) begin
        if (it.pulse_width < cfg_shadow.dz_low) begin
          want = pdog_pkg::DIR_REV;
        end else if (it.pulse_width > cfg_shadow.dz_high) begin
          want = pdog_pkg::DIR_FWD;
        end
        // opposite command releases the latch
        if (trip_latch &&
            ((trip_dir_q == pdog_pkg::DIR_FWD && want == pdog_pkg::DIR_REV) ||
             (trip_dir_q == pdog_pkg::DIR_REV && want == pdog_pkg::DIR_FWD))) begin
          trip_latch = 1'b0;
        end
      end
      if (trip_latch) begin
        want = pdog_pkg::DIR_STOP;
      end
      if (want != cmd_dir) begin
        cmd_dir   = want;
        r.changed = 1'b1;
      end
    end
    r.direction   = cmd_dir;
    r.prot_active = trip_latch;
    r.blanking    = blank_on;
    return r;
  endfunction

  function automatic pdog_pkg::item_t mk_tick(logic [31:0] t, int sr, int mr, logic [19:0] cur,
                                              int pv, logic [15:0] pw);
    pdog_pkg::item_t it;
    it.now_ms        = t;
    it.sensor_ready  = sr[0];
    it.motor_running = mr[0];
    it.current       = cur;
    it.pulse_valid   = pv[0];
    it.pulse_width   = pw;
    return it;
  endfunction

  function automatic pdog_pkg::res_t mk_res(pdog_pkg::dir_e d, int ch, int st, int tr, int pa,
                                            int bl);
    pdog_pkg::res_t r;
    r.direction   = d;
    r.changed     = ch[0];
    r.stop_req    = st[0];
    r.tripped     = tr[0];
    r.prot_active = pa[0];
    r.blanking    = bl[0];
    return r;
  endfunction

  // Predict, then hold the beat until it is taken
  task automatic send_tick(input pdog_pkg::item_t it, input logic typed,
                           input pdog_pkg::res_t typed_r);
    pdog_pkg::res_t p;
    p = guard_tick(it);
    pending_res.push_back(typed ? typed_r : p);
    in_valid_i         <= 1'b1;
    now_ms_i           <= it.now_ms;
    sensor_ready_i     <= it.sensor_ready;
    motor_running_i    <= it.motor_running;
    current_tenth_ma_i <= it.current;
    pulse_valid_i      <= it.pulse_valid;
    pulse_width_us_i   <= it.pulse_width;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic gap_in();
    if (!calm && $urandom_range(0, idle_odds) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [pdog_pkg::CfgIdxW-1:0] idx,
                           input logic [pdog_pkg::CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Full register set; spare upper data bits on 16-bit registers are junk
  task automatic load_cfg(input pdog_pkg::cfg_t c, input logic [pdog_pkg::CfgIdxW-1:0] spare);
    write_reg(pdog_pkg::REG_PULSE_MIN, {3'($urandom), c.pulse_min});
    write_reg(pdog_pkg::REG_PULSE_MAX, {3'($urandom), c.pulse_max});
    write_reg(pdog_pkg::REG_DZ_LOW,    {3'($urandom), c.dz_low});
    write_reg(pdog_pkg::REG_DZ_HIGH,   {3'($urandom), c.dz_high});
    write_reg(pdog_pkg::REG_CUR_LIMIT, c.cur_limit);
    write_reg(pdog_pkg::REG_START_DLY, {3'($urandom), c.start_dly});
    write_reg(spare, 19'($urandom));
    cfg_valid_i <= 1'b0;
    cfg_shadow = c;
  endtask

  // Wait until every result is back, plus pipeline slack
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Random tick: runs of motor on/off, currents near the limit, widths near edges
  task automatic roll_tick(input pdog_pkg::cfg_t c, output pdog_pkg::item_t it);
    int unsigned pick;
    logic [15:0] edge_w;
    it   = '0;
    pick = $urandom_range(0, 15);
    if (pick < 12) begin
      tick_ms = tick_ms + $urandom_range(1, 40);
    end else if (pick == 15) begin
      tick_ms = tick_ms + $urandom;
    end
    if ($urandom_range(0, 15) == 0) begin
      motor_on = !motor_on;
    end
    it.now_ms        = tick_ms;
    it.motor_running = motor_on;
    it.sensor_ready  = ($urandom_range(0, 7) != 0);
    case ($urandom_range(0, 7))
      0, 1, 2: it.current = 20'({1'b0, c.cur_limit}) + 20'($urandom_range(0, 4)) - 20'd2;
      3, 4:    it.current = 20'($urandom_range(0, c.cur_limit));
      5:       it.current = 20'($urandom);
      6:       it.current = {1'b1, 19'($urandom)};
      default: it.current = $urandom_range(0, 1) ? 20'h7FFFF : 20'h80000;
    endcase
    it.pulse_valid = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0, 1, 2, 3: begin
        case ($urandom_range(0, 3))
          0:       edge_w = c.pulse_min;
          1:       edge_w = c.pulse_max;
          2:       edge_w = c.dz_low;
          default: edge_w = c.dz_high;
        endcase
        it.pulse_width = edge_w + 16'($urandom_range(0, 2)) - 16'd1;
      end
      4, 5: begin
        if (c.pulse_min <= c.pulse_max) begin
          it.pulse_width = 16'($urandom_range(c.pulse_min, c.pulse_max));
        end else begin
          it.pulse_width = 16'($urandom);
        end
      end
      default: it.pulse_width = 16'($urandom);
    endcase
  endtask

  // Result checking
  task automatic match_field(input string tag, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, tag, exp_v, got_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual direction %0d",
                 $time, direction_o);
        err_cnt++;
      end else begin
        head_res = pending_res.pop_front();
        match_field("direction", int'($signed(head_res.direction)), int'(direction_o));
        match_field("direction_changed", int'(head_res.changed), int'(direction_changed_o));
        match_field("stop_request", int'(head_res.stop_req), int'(stop_request_o));
        match_field("protection_tripped", int'(head_res.tripped),
                    int'(protection_tripped_o));
        match_field("protection_active", int'(head_res.prot_active),
                    int'(protection_active_o));
        match_field("startup_blanking", int'(head_res.blanking), int'(startup_blanking_o));
      end
    end
  end

  // Result sink: random stall bursts, none in the tail
  initial begin
    out_ready_i <= 1'b1;
    forever begin
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      if (!calm) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  // Run limit
  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus
  initial begin
    pdog_pkg::cfg_t  plan;
    pdog_pkg::item_t it;
    rst_ni             <= 1'b0;
    cfg_valid_i        <= 1'b0;
    cfg_index_i        <= '0;
    cfg_data_i         <= '0;
    in_valid_i         <= 1'b0;
    now_ms_i           <= '0;
    sensor_ready_i     <= 1'b0;
    motor_running_i    <= 1'b0;
    current_tenth_ma_i <= '0;
    pulse_valid_i      <= 1'b0;
    pulse_width_us_i   <= '0;
    err_cnt    = 0;
    calm       = 1'b0;
    free_trip  = 1'b0;
    idle_odds  = 4;
    motor_on   = 1'b0;
    cfg_shadow = '{pdog_pkg::PulseMinRst, pdog_pkg::PulseMaxRst, pdog_pkg::DzLowRst,
                   pdog_pkg::DzHighRst, pdog_pkg::CurLimRst, pdog_pkg::StartDlyRst};
    cmd_dir    = pdog_pkg::DIR_STOP;
    trip_latch = 1'b0;
    trip_dir_q = pdog_pkg::DIR_STOP;
    run_stamp  = '0;
    was_on     = 1'b0;
    blank_on   = 1'b0;

    // Directed ticks on reset registers (window 900..2100, deadzone 1400..1600,
    // limit 10000, blanking 500 ms)
    dir_rows.push_back('{mk_tick(32'd0, 1, 0, 20'd0, 0, 16'd0), 1'b1,
                         mk_res(pdog_pkg::DIR_STOP, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_tick(32'd20, 1, 0, 20'd0, 1, 16'd900), 1'b1,
                         mk_res(pdog_pkg::DIR_REV, 1, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_tick(32'd40, 1, 0, 20'd0, 1, 16'd2100), 1'b1,
                         mk_res(pdog_pkg::DIR_FWD, 1, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_tick(32'd60, 1, 0, 20'd0, 1, 16'd899), 1'b1,
                         mk_res(pdog_pkg::DIR_STOP, 1, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_tick(32'd80, 1, 0, 20'd0, 1, 16'd2101), 1'b1,
                         mk_res(pdog_pkg::DIR_STOP, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_tick(32'd100, 1, 0, 20'd0, 1, 16'd1399), 1'b1,
                         mk_res(pdog_pkg::DIR_REV, 1, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_tick(32'd120, 1, 0, 20'd0, 1, 16'd1400), 1'b1,
                         mk_res(pdog_pkg::DIR_STOP, 1, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_tick(32'd140, 1, 0, 20'd0, 1, 16'd1600), 1'b0, NoRes});
    dir_rows.push_back('{mk_tick(32'd160, 1, 0, 20'd0, 1, 16'd1601), 1'b1,
                         mk_res(pdog_pkg::DIR_FWD, 1, 0, 0, 0, 0)});
    // motor start opens blanking, maximum current ignored meanwhile
    dir_rows.push_back('{mk_tick(32'd1000, 1, 1, 20'h7FFFF, 0, 16'd0), 1'b1,
                         mk_res(pdog_pkg::DIR_FWD, 0, 0, 0, 0, 1)});
    dir_rows.push_back('{mk_tick(32'd1499, 1, 1, 20'd10000, 0, 16'd0), 1'b0, NoRes});
    // blanking over, current at the limit trips while forward
    dir_rows.push_back('{mk_tick(32'd1500, 1, 1, 20'd10000, 0, 16'd0), 1'b1,
                         mk_res(pdog_pkg::DIR_FWD, 0, 1, 1, 1, 0)});
    // most negative current, forward pulse held at stop by the latch
    dir_rows.push_back('{mk_tick(32'd1520, 1, 1, 20'h80000, 1, 16'd2000), 1'b1,
                         mk_res(pdog_pkg::DIR_STOP, 1, 0, 0, 1, 0)});
    // sensor not ready skips the guard; reverse pulse releases the latch
    dir_rows.push_back('{mk_tick(32'd1540, 0, 1, 20'd10000, 1, 16'd1000), 1'b1,
                         mk_res(pdog_pkg::DIR_REV, 1, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_tick(32'd1560, 1, 1, 20'd9999, 0, 16'd0), 1'b0, NoRes});
    dir_rows.push_back('{mk_tick(32'd1580, 1, 1, 20'd10000, 0, 16'd0), 1'b1,
                         mk_res(pdog_pkg::DIR_REV, 0, 1, 1, 1, 0)});
    dir_rows.push_back('{mk_tick(32'd1600, 1, 1, 20'h7FFFF, 0, 16'd0), 1'b0, NoRes});
    dir_rows.push_back('{mk_tick(32'd1620, 1, 1, 20'd0, 1, 16'd1000), 1'b0, NoRes});
    dir_rows.push_back('{mk_tick(32'd1640, 1, 1, 20'd0, 1, 16'd3000), 1'b0, NoRes});
    dir_rows.push_back('{mk_tick(32'd1660, 1, 1, 20'd0, 1, 16'd2000), 1'b0, NoRes});
    dir_rows.push_back('{mk_tick(32'd1680, 1, 0, 20'd0, 1, 16'd0), 1'b0, NoRes});
    // blanking across the time wrap
    dir_rows.push_back('{mk_tick(32'hFFFF_FF00, 1, 1, 20'd10000, 1, 16'hFFFF), 1'b0, NoRes});
    dir_rows.push_back('{mk_tick(32'h0000_00F3, 1, 1, 20'd10000, 1, 16'd2000), 1'b0, NoRes});
    dir_rows.push_back('{mk_tick(32'h0000_00F4, 1, 1, 20'd10000, 0, 16'd0), 1'b0, NoRes});
    dir_rows.push_back('{mk_tick(32'h0000_0108, 1, 1, 20'd0, 1, 16'd1000), 1'b0, NoRes});

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      gap_in();
      send_tick(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases, one register set each
    for (int unsigned p = 1; p <= NumPhases; p++) begin
      settle();
      case (p)
        1: plan = '{16'($urandom_range(500, 1200)), 16'($urandom_range(1800, 2500)),
                    16'($urandom_range(1300, 1500)), 16'($urandom_range(1500, 1700)),
                    19'($urandom_range(0, 20000)), 16'($urandom_range(0, 300))};
        2: plan = '0;
        3: plan = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 19'h7FFFF, 16'hFFFF};
        4: plan = '{16'($urandom_range(1500, 3000)), 16'($urandom_range(500, 1400)),
                    16'($urandom_range(1000, 2000)), 16'($urandom_range(1000, 2000)),
                    19'($urandom_range(0, 20000)), 16'($urandom_range(0, 200))};
        5: plan = '{16'd800, 16'd2200, 16'($urandom_range(1600, 1900)),
                    16'($urandom_range(1100, 1400)), 19'($urandom_range(0, 20000)),
                    16'($urandom_range(0, 200))};
        default: plan = '{pdog_pkg::PulseMinRst, pdog_pkg::PulseMaxRst, pdog_pkg::DzLowRst,
                          pdog_pkg::DzHighRst, pdog_pkg::CurLimRst,
                          16'($urandom_range(0, 300))};
      endcase
      load_cfg(plan, p[0] ? CfgIdxVoidLo : CfgIdxVoidHi);
      idle_odds = $urandom_range(2, 15);
      tick_ms   = $urandom;
      for (int unsigned n = 0; n < PhaseTicks; n++) begin
        if (p == NumPhases && n >= PhaseTicks / 2) begin
          calm      = 1'b1;
          free_trip = 1'b1;
        end
        roll_tick(plan, it);
        // a trip while stopped locks the latch until reset: only in the tail
        if (!free_trip && !trip_latch && cmd_dir == pdog_pkg::DIR_STOP && it.sensor_ready &&
            it.motor_running && $signed(it.current) >= $signed({1'b0, plan.cur_limit})) begin
          it.current = {1'b1, 19'($urandom)};
        end
        gap_in();
        send_tick(it, 1'b0, NoRes);
      end
    end

    settle();
    if (err_cnt == 0 && pending_res.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
